>>> rtl/core/r2u_pkg.sv
// shared types and coefficients for the rgb pair to uyvy converter
`timescale 1ns / 1ps
package r2u_pkg;

  localparam int unsigned ProdWidth  = 24;
  localparam int unsigned LumaAccW   = 25;
  localparam int unsigned ChromaAccW = 26;
  localparam int unsigned QShift     = 16;

  localparam logic [15:0] KY_R  = 16'd19595;
  localparam logic [15:0] KY_G  = 16'd38470;
  localparam logic [15:0] KY_B  = 16'd7471;
  localparam logic [15:0] KCB_R = 16'd11058;
  localparam logic [15:0] KCB_G = 16'd21710;
  localparam logic [15:0] KCB_B = 16'd32768;
  localparam logic [15:0] KCR_R = 16'd32768;
  localparam logic [15:0] KCR_G = 16'd27439;
  localparam logic [15:0] KCR_B = 16'd5329;

  typedef struct packed {
    logic valid;
    logic last;
  } ctrl_t;

endpackage

>>> rtl/core/rgb_pair_to_uyvy.sv
// top level: rgb pixel pair in, one uyvy word out
//
// input channel: in_valid / in_stall with two 8-bit rgb pixels and last_pair
// output channel: out_valid / out_stall with cb, y0, cr, y1 and frame_end
// a word is taken at a rising edge with valid high and stall low
// one pair is accepted every cycle while the output side keeps up
// each word passes the product, sum, clamp and output registers on its way to out_*
// datapath: products, sums, truncate and clamp, then average into the
// output register; one 8x16 multiplier per coefficient per pixel
// throughput: one word per cycle while out_stall stays low, no dependence between pairs
// stall: when the output register holds a word and out_stall is high the
// whole pipeline freezes and in_stall is raised in the same cycle
// bubbles in the pipeline are carried by valid bits, never emitted
// reset: synchronous active-low rst_n clears all valid bits; no state
// is kept between pairs, so nothing else needs clearing
`timescale 1ns / 1ps
module rgb_pair_to_uyvy (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_first_red,
  input  logic [7:0] in_first_green,
  input  logic [7:0] in_first_blue,
  input  logic [7:0] in_second_red,
  input  logic [7:0] in_second_green,
  input  logic [7:0] in_second_blue,
  input  logic       in_last_pair,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_blue_chroma,
  output logic [7:0] out_first_luma,
  output logic [7:0] out_red_chroma,
  output logic [7:0] out_second_luma,
  output logic       out_frame_end
);

  logic           adv;
  r2u_pkg::ctrl_t c1_r, c2_r, c3_r;
  logic [7:0]     y0, cb0, cr0, y1, cb1, cr1;

  assign in_stall = out_valid & out_stall;
  assign adv      = ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (adv) begin
      c1_r <= '{valid: in_valid, last: in_last_pair};
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  r2u_pixel_conv u_conv0 (
    .clk         (clk),
    .en          (adv),
    .red         (in_first_red),
    .green       (in_first_green),
    .blue        (in_first_blue),
    .luma        (y0),
    .blue_chroma (cb0),
    .red_chroma  (cr0)
  );

  r2u_pixel_conv u_conv1 (
    .clk         (clk),
    .en          (adv),
    .red         (in_second_red),
    .green       (in_second_green),
    .blue        (in_second_blue),
    .luma        (y1),
    .blue_chroma (cb1),
    .red_chroma  (cr1)
  );

  r2u_pack u_pack (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (adv),
    .ctrl            (c3_r),
    .luma0           (y0),
    .cb0             (cb0),
    .cr0             (cr0),
    .luma1           (y1),
    .cb1             (cb1),
    .cr1             (cr1),
    .out_valid       (out_valid),
    .out_blue_chroma (out_blue_chroma),
    .out_first_luma  (out_first_luma),
    .out_red_chroma  (out_red_chroma),
    .out_second_luma (out_second_luma),
    .out_frame_end   (out_frame_end)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> c1_r.valid)
    else $error("accepted word missing from first stage");

  a_freeze_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(c1_r) && $stable(c2_r) && $stable(c3_r)))
    else $error("pipeline moved while stalled");

  a_advance_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && c3_r.valid) |=> out_valid)
    else $error("word lost between last stage and output");

endmodule

>>> rtl/core/r2u_pixel_conv.sv
// three-stage rgb to full-range ycbcr converter for one pixel
`timescale 1ns / 1ps
module r2u_pixel_conv (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic [7:0] luma,
  output logic [7:0] blue_chroma,
  output logic [7:0] red_chroma
);

  logic [r2u_pkg::ProdWidth-1:0]  py_r_r, py_g_r, py_b_r;
  logic [r2u_pkg::ProdWidth-1:0]  pcb_r_r, pcb_g_r, pcb_b_r;
  logic [r2u_pkg::ProdWidth-1:0]  pcr_r_r, pcr_g_r, pcr_b_r;
  logic [r2u_pkg::LumaAccW-1:0]   y_acc_r;
  logic [r2u_pkg::ChromaAccW-1:0] cb_acc_r, cr_acc_r;
  logic [7:0]                     luma_r, cb_r, cr_r;
  logic [7:0]                     luma_nxt, cb_nxt, cr_nxt;

  logic [r2u_pkg::ChromaAccW-1:0] cb_mag, cr_mag;
  logic [9:0]                     cb_q, cr_q;
  logic [8:0]                     y_q;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      py_r_r  <= r2u_pkg::ProdWidth'(red)   * r2u_pkg::ProdWidth'(r2u_pkg::KY_R);
      py_g_r  <= r2u_pkg::ProdWidth'(green) * r2u_pkg::ProdWidth'(r2u_pkg::KY_G);
      py_b_r  <= r2u_pkg::ProdWidth'(blue)  * r2u_pkg::ProdWidth'(r2u_pkg::KY_B);
      pcb_r_r <= r2u_pkg::ProdWidth'(red)   * r2u_pkg::ProdWidth'(r2u_pkg::KCB_R);
      pcb_g_r <= r2u_pkg::ProdWidth'(green) * r2u_pkg::ProdWidth'(r2u_pkg::KCB_G);
      pcb_b_r <= r2u_pkg::ProdWidth'(blue)  * r2u_pkg::ProdWidth'(r2u_pkg::KCB_B);
      pcr_r_r <= r2u_pkg::ProdWidth'(red)   * r2u_pkg::ProdWidth'(r2u_pkg::KCR_R);
      pcr_g_r <= r2u_pkg::ProdWidth'(green) * r2u_pkg::ProdWidth'(r2u_pkg::KCR_G);
      pcr_b_r <= r2u_pkg::ProdWidth'(blue)  * r2u_pkg::ProdWidth'(r2u_pkg::KCR_B);
    end
  end

  // stage 2: sums, chroma in two's complement
  always_ff @(posedge clk) begin
    if (en) begin
      y_acc_r  <= r2u_pkg::LumaAccW'(py_r_r) + r2u_pkg::LumaAccW'(py_g_r)
                + r2u_pkg::LumaAccW'(py_b_r);
      cb_acc_r <= r2u_pkg::ChromaAccW'(pcb_b_r) - r2u_pkg::ChromaAccW'(pcb_r_r)
                - r2u_pkg::ChromaAccW'(pcb_g_r);
      cr_acc_r <= r2u_pkg::ChromaAccW'(pcr_r_r) - r2u_pkg::ChromaAccW'(pcr_g_r)
                - r2u_pkg::ChromaAccW'(pcr_b_r);
    end
  end

  // stage 3: truncate toward zero, clamp, offset chroma
  always_comb begin
    y_q    = y_acc_r[r2u_pkg::LumaAccW-1:r2u_pkg::QShift];
    cb_mag = cb_acc_r[r2u_pkg::ChromaAccW-1] ? (r2u_pkg::ChromaAccW'(0) - cb_acc_r) : cb_acc_r;
    cr_mag = cr_acc_r[r2u_pkg::ChromaAccW-1] ? (r2u_pkg::ChromaAccW'(0) - cr_acc_r) : cr_acc_r;
    cb_q   = cb_mag[r2u_pkg::ChromaAccW-1:r2u_pkg::QShift];
    cr_q   = cr_mag[r2u_pkg::ChromaAccW-1:r2u_pkg::QShift];

    luma_nxt = (y_q > 9'd255) ? 8'd255 : y_q[7:0];

    if (!cb_acc_r[r2u_pkg::ChromaAccW-1]) begin
      cb_nxt = (cb_q > 10'd127) ? 8'd255 : 8'(10'd128 + cb_q);
    end else begin
      cb_nxt = (cb_q > 10'd128) ? 8'd0 : 8'(10'd128 - cb_q);
    end

    if (!cr_acc_r[r2u_pkg::ChromaAccW-1]) begin
      cr_nxt = (cr_q > 10'd127) ? 8'd255 : 8'(10'd128 + cr_q);
    end else begin
      cr_nxt = (cr_q > 10'd128) ? 8'd0 : 8'(10'd128 - cr_q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      luma_r <= luma_nxt;
      cb_r   <= cb_nxt;
      cr_r   <= cr_nxt;
    end
  end

  assign luma        = luma_r;
  assign blue_chroma = cb_r;
  assign red_chroma  = cr_r;

endmodule

>>> rtl/core/r2u_pack.sv
// chroma averaging and uyvy output register
`timescale 1ns / 1ps
module r2u_pack (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  r2u_pkg::ctrl_t ctrl,
  input  logic [7:0]     luma0,
  input  logic [7:0]     cb0,
  input  logic [7:0]     cr0,
  input  logic [7:0]     luma1,
  input  logic [7:0]     cb1,
  input  logic [7:0]     cr1,
  output logic           out_valid,
  output logic [7:0]     out_blue_chroma,
  output logic [7:0]     out_first_luma,
  output logic [7:0]     out_red_chroma,
  output logic [7:0]     out_second_luma,
  output logic           out_frame_end
);

  logic       valid_r;
  logic [7:0] cb_r, y0_r, cr_r, y1_r;
  logic       last_r;
  logic [8:0] cb_sum, cr_sum;

  assign cb_sum = 9'(cb0) + 9'(cb1);
  assign cr_sum = 9'(cr0) + 9'(cr1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cb_r   <= cb_sum[8:1];
      cr_r   <= cr_sum[8:1];
      y0_r   <= luma0;
      y1_r   <= luma1;
      last_r <= ctrl.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_blue_chroma = cb_r;
  assign out_first_luma  = y0_r;
  assign out_red_chroma  = cr_r;
  assign out_second_luma = y1_r;
  assign out_frame_end   = last_r;

endmodule

>>> bench/rgb_pair_to_uyvy_test.sv
// self-checking testbench for the rgb pair to uyvy converter
`timescale 1ns / 1ps
module rgb_pair_to_uyvy_test;

  localparam int CycleLimit  = 400000;
  localparam int RandomPairs = 450;
  localparam int DrainCycles = 12;

  localparam int LumaR   = 19595;
  localparam int LumaG   = 38470;
  localparam int LumaB   = 7471;
  localparam int BlueR   = 11058;
  localparam int BlueG   = 21710;
  localparam int BlueB   = 32768;
  localparam int RedR    = 32768;
  localparam int RedG    = 27439;
  localparam int RedB    = 5329;

  typedef struct packed {
    logic [7:0] r0;
    logic [7:0] g0;
    logic [7:0] b0;
    logic [7:0] r1;
    logic [7:0] g1;
    logic [7:0] b1;
    logic       last;
  } pixel_pair_t;

  typedef struct packed {
    logic [7:0] cb;
    logic [7:0] y0;
    logic [7:0] cr;
    logic [7:0] y1;
    logic       frame_end;
  } uyvy_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_first_red = '0;
  logic [7:0] in_first_green = '0;
  logic [7:0] in_first_blue = '0;
  logic [7:0] in_second_red = '0;
  logic [7:0] in_second_green = '0;
  logic [7:0] in_second_blue = '0;
  logic       in_last_pair = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_blue_chroma;
  logic [7:0] out_first_luma;
  logic [7:0] out_red_chroma;
  logic [7:0] out_second_luma;
  logic       out_frame_end;

  pixel_pair_t pending_pairs[$];
  uyvy_word_t  expected_words[$];
  logic        pair_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  rgb_pair_to_uyvy DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_red    (in_first_red),
    .in_first_green  (in_first_green),
    .in_first_blue   (in_first_blue),
    .in_second_red   (in_second_red),
    .in_second_green (in_second_green),
    .in_second_blue  (in_second_blue),
    .in_last_pair    (in_last_pair),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_blue_chroma (out_blue_chroma),
    .out_first_luma  (out_first_luma),
    .out_red_chroma  (out_red_chroma),
    .out_second_luma (out_second_luma),
    .out_frame_end   (out_frame_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int q16_trunc(int acc);
    if (acc < 0) begin
      return -((-acc) >> 16);
    end
    return acc >> 16;
  endfunction

  function automatic int clamp_range(int v, int lo, int hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic void pixel_to_ycc(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, output int y,
                                       output int cb, output int cr);
    int ri;
    int gi;
    int bi;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    y  = clamp_range(q16_trunc(LumaR * ri + LumaG * gi + LumaB * bi), 0, 255);
    cb = clamp_range(q16_trunc(BlueB * bi - BlueR * ri - BlueG * gi), -128, 127) + 128;
    cr = clamp_range(q16_trunc(RedR * ri - RedG * gi - RedB * bi), -128, 127) + 128;
  endfunction

  function automatic uyvy_word_t pack_uyvy(pixel_pair_t p);
    uyvy_word_t w;
    int y0, cb0, cr0, y1, cb1, cr1;
    pixel_to_ycc(p.r0, p.g0, p.b0, y0, cb0, cr0);
    pixel_to_ycc(p.r1, p.g1, p.b1, y1, cb1, cr1);
    w.cb        = 8'((cb0 + cb1) >> 1);
    w.y0        = 8'(y0);
    w.cr        = 8'((cr0 + cr1) >> 1);
    w.y1        = 8'(y1);
    w.frame_end = p.last;
    return w;
  endfunction

  function automatic pixel_pair_t make_pair(logic [7:0] r0, logic [7:0] g0, logic [7:0] b0,
                                            logic [7:0] r1, logic [7:0] g1, logic [7:0] b1,
                                            logic last);
    pixel_pair_t p;
    p.r0 = r0;
    p.g0 = g0;
    p.b0 = b0;
    p.r1 = r1;
    p.g1 = g1;
    p.b1 = b1;
    p.last = last;
    return p;
  endfunction

  function automatic logic [7:0] random_component(int style);
    int pick;
    pick = $urandom_range(0, 3);
    case (style)
      0: begin
        return 8'($urandom_range(0, 255));
      end
      1: begin
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        if (pick == 2) return 8'($urandom_range(0, 3));
        return 8'($urandom_range(252, 255));
      end
      default: begin
        return 8'($urandom_range(96, 160));
      end
    endcase
  endfunction

  function automatic pixel_pair_t random_pair(logic last);
    pixel_pair_t p;
    int style;
    style = $urandom_range(0, 9);
    style = (style < 6) ? 0 : (style < 8) ? 1 : 2;
    p.r0 = random_component(style);
    p.g0 = random_component(style);
    p.b0 = random_component(style);
    if ($urandom_range(0, 7) == 0) begin
      p.r1 = p.r0;
      p.g1 = p.g0;
      p.b1 = p.b0;
    end else begin
      p.r1 = random_component(style);
      p.g1 = random_component(style);
      p.b1 = random_component(style);
    end
    p.last = last;
    return p;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // driver
  always @(negedge clk) begin
    pixel_pair_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pair_taken) begin
      if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_pairs.pop_front();
        in_valid        <= 1'b1;
        in_first_red    <= nxt.r0;
        in_first_green  <= nxt.g0;
        in_first_blue   <= nxt.b0;
        in_second_red   <= nxt.r1;
        in_second_green <= nxt.g1;
        in_second_blue  <= nxt.b1;
        in_last_pair    <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // monitor and predictor
  always @(posedge clk) begin
    uyvy_word_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      pair_taken <= rst_n && in_valid && !in_stall;
      if (rst_n && in_valid && !in_stall) begin
        expected_words.push_back(pack_uyvy(make_pair(in_first_red, in_first_green,
          in_first_blue, in_second_red, in_second_green, in_second_blue, in_last_pair)));
      end
      if (rst_n && out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("word with no pair pending: cb %0d y0 %0d cr %0d y1 %0d",
                 out_blue_chroma, out_first_luma, out_red_chroma, out_second_luma);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("blue_chroma", want.cb, out_blue_chroma);
          check_field("first_luma", want.y0, out_first_luma);
          check_field("red_chroma", want.cr, out_red_chroma);
          check_field("second_luma", want.y1, out_second_luma);
          check_field("frame_end", want.frame_end, out_frame_end);
        end
      end
    end
  end

  initial begin
    int send_pct[3];
    int recv_pct[3];
    int frame_left;
    send_pct = '{15, 75, 0};
    recv_pct = '{75, 15, 0};
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    pending_pairs.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    pending_pairs.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    pending_pairs.push_back(make_pair(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0));
    pending_pairs.push_back(make_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0));
    pending_pairs.push_back(make_pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 1'b0));
    pending_pairs.push_back(make_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0));
    pending_pairs.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
    pending_pairs.push_back(make_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0));
    pending_pairs.push_back(make_pair(8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0));
    pending_pairs.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1));
    pending_pairs.push_back(make_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0));
    pending_pairs.push_back(make_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0));
    pending_pairs.push_back(make_pair(8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 1'b0));
    pending_pairs.push_back(make_pair(8'd0, 8'd0, 8'd1, 8'd254, 8'd254, 8'd254, 1'b0));
    pending_pairs.push_back(make_pair(8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127, 1'b0));
    pending_pairs.push_back(make_pair(8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 1'b1));
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      @(posedge clk);
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      frame_left = $urandom_range(1, 40);
      for (int n = 0; n < RandomPairs; n++) begin
        frame_left--;
        if ($urandom_range(0, 19) == 0) begin
          pending_pairs.push_back(random_pair(1'($urandom_range(0, 1))));
        end else begin
          pending_pairs.push_back(random_pair(frame_left == 0));
        end
        if (frame_left == 0) begin
          frame_left = $urandom_range(1, 40);
        end
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
